// File: sv/shp3_pkg.sv
// Shared types and constants of the 3x3 RGB sharpening unit.
package shp3_pkg;

    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = CH_W * NUM_CH;
    localparam int SUM_W  = CH_W + 3;
    localparam int GAIN_W = 12;
    localparam int LINE_W = 16;
    localparam int CFG_W  = 16;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_GAIN          = 2'd0,
        CFG_COLUMN_LENGTH = 2'd1,
        CFG_LINE_COUNT    = 2'd2,
        CFG_MAX_VALUE     = 2'd3
    } t_cfg_idx;

    // Per-item control that travels with a pixel through the read stage.
    typedef struct packed {
        logic pix;      // Real pixel: updates the window and the older line.
        logic emit;     // Produces a result.
        logic inner;    // Result is the sharpened value, not a pass-through.
        logic mem;      // Pass-through value comes from the middle line store.
        logic last;     // Final result of the frame.
    } t_item_ctl;

endpackage

// File: sv/sharpen_3x3_rgb_unit.sv
// Top level of the streaming 3x3 Laplacian sharpening unit for RGB pixels.
// Throughput: one transaction per clock on the input, one result per clock on the output,
// as long as the result side does not stall. A result passes the stage 1, stage 2, stage 3
// and output registers. The result for a pixel is caused one line plus one pixel later in
// the stream.
// Reset clears the position counters and pipeline valids and loads the configuration defaults;
// the two line stores are not cleared and hold no meaning until a frame writes them.
module sharpen_3x3_rgb_unit import shp3_pkg::*; #(
    parameter int MAX_COLUMN_LENGTH = 2048,
    parameter int GAIN_FRAC_BITS    = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Pixel input stream.
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [PIX_W-1:0]   i_s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic               i_s_tuser,   // flush [0]
    // Result stream.
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [PIX_W-1:0]   o_m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic               o_m_tlast,   // last_of_frame
    // Configuration write channel.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    // Address width of the line stores and width of a count that can hold the full length.
    localparam int ADDR_W  = $clog2(MAX_COLUMN_LENGTH);
    localparam int LEN_W   = $clog2(MAX_COLUMN_LENGTH + 1);
    localparam int CMP_W   = (LEN_W > GAIN_W) ? LEN_W : GAIN_W;
    // The exact result is num / 2^SHIFT with num = centre*2^SHIFT + gain*(8*centre - sum).
    localparam int SHIFT   = GAIN_FRAC_BITS + 3;
    localparam int DIFF_W  = SUM_W + 1;
    localparam int PROD_W  = GAIN_W + 1 + DIFF_W;
    localparam int CTERM_W = CH_W + SHIFT + 1;
    localparam int NUM_W   = ((PROD_W > CTERM_W) ? PROD_W : CTERM_W) + 1;
    localparam int LEN_RST = (2048 > MAX_COLUMN_LENGTH) ? MAX_COLUMN_LENGTH : 2048;
    localparam logic signed [NUM_W-1:0] NUM_MAX = NUM_W'(255) <<< SHIFT;

    // ------------------------------------------------------------------------
    // Configuration registers. The column length is stored already clamped to
    // the range the line stores support, the line count to at least three.
    // ------------------------------------------------------------------------
    logic [GAIN_W-1:0] r_gain;
    logic [LEN_W-1:0]  r_len;
    logic [LINE_W-1:0] r_lines;
    logic [CH_W-1:0]   r_max_value;
    logic [LEN_W-1:0]  n_len;
    logic [LINE_W-1:0] n_lines;
    logic [CMP_W-1:0]  cfg_len_raw;
    logic              cfg_wr;
    logic              cfg_restart;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign cfg_len_raw = CMP_W'(i_cfg_data[GAIN_W-1:0]);

    always_comb begin
        if (cfg_len_raw < CMP_W'(3)) begin
            n_len = LEN_W'(3);
        end else if (cfg_len_raw > CMP_W'(MAX_COLUMN_LENGTH)) begin
            n_len = LEN_W'(MAX_COLUMN_LENGTH);
        end else begin
            n_len = LEN_W'(cfg_len_raw);
        end
        if (i_cfg_data < LINE_W'(3)) begin
            n_lines = LINE_W'(3);
        end else begin
            n_lines = i_cfg_data;
        end
    end

    // A change of geometry restarts the frame.
    assign cfg_restart = cfg_wr && ((i_cfg_index == CFG_COLUMN_LENGTH) ||
                                    (i_cfg_index == CFG_LINE_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= '0;
            r_len       <= LEN_W'(LEN_RST);
            r_lines     <= LINE_W'(3);
            r_max_value <= CH_W'(255);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_GAIN:          r_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_COLUMN_LENGTH: r_len       <= n_len;
                CFG_LINE_COUNT:    r_lines     <= n_lines;
                CFG_MAX_VALUE:     r_max_value <= i_cfg_data[CH_W-1:0];
                default:           r_gain      <= r_gain;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline handshake. Each stage moves on when the next one is empty or
    // moving, so the input keeps flowing while a result waits at the output
    // as long as any stage holds a bubble.
    // ------------------------------------------------------------------------
    logic r1_valid, r2_valid, r3_valid, r_o_valid;
    logic rdy1, rdy2, rdy3, rdy_out;
    logic s_acc;

    assign rdy_out    = !r_o_valid || i_m_tready;
    assign rdy3       = !r3_valid || rdy_out;
    assign rdy2       = !r2_valid || rdy3;
    assign rdy1       = !r1_valid || rdy2;
    assign o_s_tready = rdy1;
    assign s_acc      = i_s_tvalid && rdy1;

    // ------------------------------------------------------------------------
    // Position tracking. While pixels of the frame arrive, r_pos and r_line
    // walk the frame. Once all lines are in, the unit drains: every
    // transaction then releases one pending border result, first the center
    // entry of the window, then the whole last line from the middle store.
    // ------------------------------------------------------------------------
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [LINE_W-1:0] r_line, n_line;
    logic              r_drain, n_drain;
    logic [LEN_W-1:0]  r_dcnt, n_dcnt;
    logic              pix_acc;
    logic              drain_acc;
    logic              line_end;
    logic              frame_end;
    logic              drain_end;
    t_item_ctl         ctl0;

    assign pix_acc   = s_acc && !r_drain && !i_s_tuser;
    assign drain_acc = s_acc && r_drain;
    assign line_end  = (LEN_W'(r_pos) == (r_len - LEN_W'(1)));
    assign frame_end = (r_line == (r_lines - LINE_W'(1)));
    assign drain_end = (r_dcnt == r_len);

    always_comb begin
        n_pos   = r_pos;
        n_line  = r_line;
        n_drain = r_drain;
        n_dcnt  = r_dcnt;
        if (cfg_restart) begin
            n_pos   = '0;
            n_line  = '0;
            n_drain = 1'b0;
            n_dcnt  = '0;
        end else if (pix_acc) begin
            if (line_end) begin
                n_pos  = '0;
                n_line = r_line + LINE_W'(1);
                if (frame_end) begin
                    n_drain = 1'b1;
                    n_dcnt  = '0;
                end
            end else begin
                n_pos = r_pos + ADDR_W'(1);
            end
        end else if (drain_acc) begin
            if (drain_end) begin
                n_pos   = '0;
                n_line  = '0;
                n_drain = 1'b0;
                n_dcnt  = '0;
            end else begin
                n_dcnt = r_dcnt + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_line  <= '0;
            r_drain <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_drain <= n_drain;
            r_dcnt  <= n_dcnt;
        end
    end

    // Control of the transaction being accepted. A pixel produces a result
    // from the second line on, except at the very first column of line one;
    // the result is a true sharpened value only away from the frame border.
    always_comb begin
        if (r_drain) begin
            ctl0.pix   = 1'b0;
            ctl0.emit  = 1'b1;
            ctl0.inner = 1'b0;
            ctl0.mem   = (r_dcnt != '0);
            ctl0.last  = drain_end;
        end else begin
            ctl0.pix   = 1'b1;
            ctl0.emit  = (r_line != '0) && ((r_pos != '0) || (r_line != LINE_W'(1)));
            ctl0.inner = (r_pos >= ADDR_W'(2)) && (r_line >= LINE_W'(2));
            ctl0.mem   = 1'b0;
            ctl0.last  = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Line stores. The middle line is read and overwritten with the incoming
    // pixel in the accept cycle; the older line receives the old middle value
    // from stage 1, once the read data is back. Same-address accesses are
    // at least three pixels apart, so the late write never meets a read.
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0]  top_rd;
    logic [PIX_W-1:0]  mid_rd;
    logic [ADDR_W-1:0] mid_raddr;
    logic              win_upd;
    logic [ADDR_W-1:0] r1_addr;

    assign mid_raddr = r_drain ? ADDR_W'(r_dcnt - LEN_W'(1)) : r_pos;

    shp3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLUMN_LENGTH)
    ) u_middle_line (
        .i_clk   (i_clk),
        .i_we    (pix_acc),
        .i_waddr (r_pos),
        .i_wdata (i_s_tdata),
        .i_re    (pix_acc || drain_acc),
        .i_raddr (mid_raddr),
        .o_rdata (mid_rd)
    );

    shp3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLUMN_LENGTH)
    ) u_older_line (
        .i_clk   (i_clk),
        .i_we    (win_upd),
        .i_waddr (r1_addr),
        .i_wdata (mid_rd),
        .i_re    (pix_acc),
        .i_raddr (r_pos),
        .o_rdata (top_rd)
    );

    // ------------------------------------------------------------------------
    // Stage 1: line store data is back. The window holds the previous two
    // columns (entries 0..2 the newer column top to bottom, 3..5 the older
    // one); together with top, middle and the new pixel it forms the 3x3
    // neighborhood whose center is window entry 1.
    // ------------------------------------------------------------------------
    t_item_ctl        r1_ctl;
    logic [PIX_W-1:0] r1_bot;
    logic [PIX_W-1:0] r_win [6];
    logic [PIX_W-1:0] px1;
    logic [CH_W-1:0]  ctr1 [NUM_CH];
    logic [SUM_W-1:0] sum1 [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (rdy1) begin
            r1_valid <= s_acc && (r_drain || !i_s_tuser);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_ctl  <= ctl0;
            r1_bot  <= i_s_tdata;
            r1_addr <= r_pos;
        end
    end

    assign win_upd = r1_valid && rdy2 && r1_ctl.pix;

    always_ff @(posedge i_clk) begin
        if (win_upd) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= top_rd;
            r_win[1] <= mid_rd;
            r_win[2] <= r1_bot;
        end
    end

    assign px1 = r1_ctl.mem ? mid_rd : r_win[1];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            ctr1[c] = r_win[1][c*CH_W +: CH_W];
            sum1[c] = SUM_W'(r_win[0][c*CH_W +: CH_W]) + SUM_W'(r_win[2][c*CH_W +: CH_W])
                    + SUM_W'(r_win[3][c*CH_W +: CH_W]) + SUM_W'(r_win[4][c*CH_W +: CH_W])
                    + SUM_W'(r_win[5][c*CH_W +: CH_W]) + SUM_W'(top_rd[c*CH_W +: CH_W])
                    + SUM_W'(mid_rd[c*CH_W +: CH_W])   + SUM_W'(r1_bot[c*CH_W +: CH_W]);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: center and neighbor sum per channel. Only items with a result
    // enter here.
    // ------------------------------------------------------------------------
    logic [CH_W-1:0]          r2_ctr [NUM_CH];
    logic [SUM_W-1:0]         r2_sum [NUM_CH];
    logic [PIX_W-1:0]         r2_px;
    logic                     r2_inner;
    logic                     r2_last;
    logic signed [DIFF_W-1:0] diff2 [NUM_CH];
    logic signed [PROD_W-1:0] prod2 [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (rdy2) begin
            r2_valid <= r1_valid && r1_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_ctr   <= ctr1;
            r2_sum   <= sum1;
            r2_px    <= px1;
            r2_inner <= r1_ctl.inner;
            r2_last  <= r1_ctl.last;
        end
    end

    // Laplacian term scaled by the gain: gain * (8*centre - sum).
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            diff2[c] = $signed({1'b0, r2_ctr[c], 3'b000}) - $signed({1'b0, r2_sum[c]});
            prod2[c] = $signed({1'b0, r_gain}) * diff2[c];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: products registered; add the scaled center, clamp and truncate.
    // ------------------------------------------------------------------------
    logic signed [PROD_W-1:0] r3_prod [NUM_CH];
    logic [CH_W-1:0]          r3_ctr [NUM_CH];
    logic [PIX_W-1:0]         r3_px;
    logic                     r3_inner;
    logic                     r3_last;
    logic signed [NUM_W-1:0]  num3 [NUM_CH];
    logic [PIX_W-1:0]         res3;
    logic [PIX_W-1:0]         px3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (rdy3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_prod  <= prod2;
            r3_ctr   <= r2_ctr;
            r3_px    <= r2_px;
            r3_inner <= r2_inner;
            r3_last  <= r2_last;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            num3[c] = $signed({{(NUM_W-CH_W-SHIFT){1'b0}}, r3_ctr[c], {SHIFT{1'b0}}})
                    + $signed({{(NUM_W-PROD_W){r3_prod[c][PROD_W-1]}}, r3_prod[c]});
            if (num3[c][NUM_W-1]) begin
                res3[c*CH_W +: CH_W] = '0;
            end else if (num3[c] > NUM_MAX) begin
                res3[c*CH_W +: CH_W] = r_max_value;
            end else begin
                res3[c*CH_W +: CH_W] = num3[c][SHIFT +: CH_W];
            end
        end
    end

    assign px3 = r3_inner ? res3 : r3_px;

    // ------------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0] r_o_data;
    logic             r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (rdy_out) begin
            r_o_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out) begin
            r_o_data <= px3;
            r_o_last <= r3_last;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

endmodule

// File: sv/shp3_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module shp3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the streaming 3x3 RGB sharpening unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import shp3_pkg::*;

    localparam int MAX_COLS       = 2048;
    localparam int FRAC_BITS      = 8;
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 6;
    localparam int MAX_IDLE       = 13;
    localparam int SETTLE_CYCLES  = 10;   // time for the pipeline to settle
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int WIDE_ITEMS     = 150;
    localparam int MAX_PRINTED    = 100;

    // Pixel content styles for generated frames.
    localparam int PIX_NOISE   = 0;   // uniform random channels
    localparam int PIX_EXTREME = 1;   // every channel is 0 or 255, drives the clamps
    localparam int PIX_FLAT    = 2;   // narrow band around mid grey

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } t_pixel_result;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [PIX_W-1:0]  i_s_tdata   = '0;
    logic              i_s_tuser   = 1'b0;
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [PIX_W-1:0]  o_m_tdata;
    logic              o_m_tlast;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    t_cfg_idx          i_cfg_index = CFG_GAIN;
    logic [CFG_W-1:0]  i_cfg_data  = '0;

    int src_idle_max  = MAX_IDLE;
    int sink_idle_max = MAX_IDLE;
    int fail_count    = 0;
    int results_seen  = 0;
    int quiet_cycles  = 0;

    t_pixel_result pending_pixels[$];

    sharpen_3x3_rgb_unit #(
        .MAX_COLUMN_LENGTH (MAX_COLS),
        .GAIN_FRAC_BITS    (FRAC_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #(CLK_HALF);
        i_clk = 1'b1;
        #(CLK_HALF);
    end

    // ------------------------------------------------------------------
    // Sharpening predictor: its own copy of the line stores, the window,
    // the frame counters and the register file.
    // ------------------------------------------------------------------
    bit [PIX_W-1:0]  older_row  [MAX_COLS];
    bit [PIX_W-1:0]  middle_row [MAX_COLS];
    bit [PIX_W-1:0]  window_px  [6];
    int unsigned     col_pos     = 0;
    int unsigned     row_pos     = 0;
    int unsigned     results_out = 0;
    bit [GAIN_W-1:0] gain_k      = '0;
    bit [12:0]       cols_cfg    = 13'd2048;
    bit [LINE_W-1:0] rows_cfg    = 16'd3;
    bit [CH_W-1:0]   max_level   = 8'd255;

    function automatic int unsigned line_len();
        if (cols_cfg < 3) return 3;
        if (cols_cfg > MAX_COLS) return MAX_COLS;
        return cols_cfg;
    endfunction

    function automatic int unsigned frame_rows();
        return (rows_cfg < 3) ? 3 : rows_cfg;
    endfunction

    // (k+1)*centre - (k/8)*ring, kept exact by scaling with 8 * 2^FRAC_BITS.
    function automatic logic [CH_W-1:0] sharpen_level(input int unsigned centre,
                                                      input int unsigned ring_sum);
        longint scale;
        longint acc;
        scale = longint'(1) << (FRAC_BITS + 3);
        acc   = longint'(centre) * scale +
                longint'(gain_k) * (8 * longint'(centre) - longint'(ring_sum));
        if (acc < 0) return '0;
        if (acc > 255 * scale) return max_level;
        return CH_W'(acc / scale);
    endfunction

    function automatic void queue_result(input logic [PIX_W-1:0] px, input logic last);
        t_pixel_result r;
        r.red   = px[0 +: CH_W];
        r.green = px[CH_W +: CH_W];
        r.blue  = px[2*CH_W +: CH_W];
        r.last  = last;
        pending_pixels.push_back(r);
    endfunction

    function automatic void latch_register(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        case (idx)
            CFG_GAIN: begin
                gain_k = value[GAIN_W-1:0];
            end
            CFG_COLUMN_LENGTH: begin
                cols_cfg = {1'b0, value[11:0]};
                col_pos = 0; row_pos = 0; results_out = 0;
            end
            CFG_LINE_COUNT: begin
                rows_cfg = value[LINE_W-1:0];
                col_pos = 0; row_pos = 0; results_out = 0;
            end
            CFG_MAX_VALUE: begin
                max_level = value[CH_W-1:0];
            end
        endcase
    endfunction

    function automatic void predict_sharpened(input logic [PIX_W-1:0] pix, input logic flush);
        int unsigned    len, rows, total, q, col, i, j, oc, orow, ring, sh;
        logic [PIX_W-1:0] top, mid, px;
        logic           last;
        len  = line_len();
        rows = frame_rows();

        // Once the whole frame is in, every item drains one border pixel from the stores.
        if (row_pos >= rows) begin
            total = len * rows;
            q = results_out;
            if (q >= total) begin
                col_pos = 0; row_pos = 0; results_out = 0;
                return;
            end
            col  = q % len;
            px   = (q / len == rows - 1) ? middle_row[col] : older_row[col];
            last = (q + 1 == total);
            queue_result(px, last);
            if (last) begin
                col_pos = 0; row_pos = 0; results_out = 0;
            end else begin
                results_out = q + 1;
            end
            return;
        end

        // A flush while the frame still expects pixels changes nothing.
        if (flush) return;

        i = col_pos;
        j = row_pos;
        if (i >= len) i = len - 1;
        top = older_row[i];
        mid = middle_row[i];

        // The window centre is the pixel one line plus one pixel back.
        if (j >= 1 && (i >= 1 || j >= 2)) begin
            oc   = (i == 0) ? len - 1 : i - 1;
            orow = (i == 0) ? j - 2 : j - 1;
            px   = window_px[1];
            if (oc >= 1 && oc + 2 <= len && orow >= 1 && orow + 2 <= rows) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    sh   = c * CH_W;
                    ring = window_px[0][sh +: CH_W] + window_px[2][sh +: CH_W] +
                           window_px[3][sh +: CH_W] + window_px[4][sh +: CH_W] +
                           window_px[5][sh +: CH_W] + top[sh +: CH_W] +
                           mid[sh +: CH_W] + pix[sh +: CH_W];
                    px[sh +: CH_W] = sharpen_level(window_px[1][sh +: CH_W], ring);
                end
            end
            queue_result(px, 1'b0);
            results_out++;
        end

        older_row[i]  = mid;
        middle_row[i] = pix;
        window_px[3]  = window_px[0];
        window_px[4]  = window_px[1];
        window_px[5]  = window_px[2];
        window_px[0]  = top;
        window_px[1]  = mid;
        window_px[2]  = pix;

        i++;
        if (i >= len) begin
            i = 0;
            row_pos = j + 1;
        end
        col_pos = i;
    endfunction

    // ------------------------------------------------------------------
    // Result checking, result-side stalls and the watchdog.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("%0t ns: result %0d: %s is 0x%0h, expected 0x%0h",
                     $time, results_seen, what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_pixel_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected result, tdata", o_m_tdata, 0);
            end else begin
                want = pending_pixels.pop_front();
                if (o_m_tdata[0 +: CH_W] !== want.red)
                    report_mismatch("red_out", o_m_tdata[0 +: CH_W], want.red);
                if (o_m_tdata[CH_W +: CH_W] !== want.green)
                    report_mismatch("green_out", o_m_tdata[CH_W +: CH_W], want.green);
                if (o_m_tdata[2*CH_W +: CH_W] !== want.blue)
                    report_mismatch("blue_out", o_m_tdata[2*CH_W +: CH_W], want.blue);
                if (o_m_tlast !== want.last)
                    report_mismatch("last_of_frame", o_m_tlast, want.last);
            end
            results_seen++;
        end
    end

    // The result side draws a fresh stall before every transaction.
    initial begin : result_sink
        int stall;
        @(negedge i_clk);
        forever begin
            stall = $urandom_range(0, sink_idle_max);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** sharpen_3x3_rgb_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [PIX_W-1:0] pix, input logic flush);
        int gap;
        gap = $urandom_range(0, src_idle_max);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pix;
        i_s_tuser  <= flush;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_sharpened(pix, flush);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        latch_register(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop sending, let every expected result out, then give the pipeline time to settle.
    task automatic quiesce();
        i_s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] make_pixel(input int style);
        logic [PIX_W-1:0] px;
        px = PIX_W'($urandom);
        for (int c = 0; c < NUM_CH; c++) begin
            if (style == PIX_EXTREME)
                px[c*CH_W +: CH_W] = {CH_W{px[c*CH_W]}};
            else if (style == PIX_FLAT)
                px[c*CH_W +: CH_W] = 8'd112 + {4'd0, px[c*CH_W +: 4]};
        end
        return px;
    endfunction

    // Pixels of one frame, optionally sprinkled with ignored flushes, then the drain items,
    // which are a mix of flushes and pixels whose data the block discards.
    task automatic send_frame(input int pixels, input int drains, input int style,
                              input bit noise);
        for (int n = 0; n < pixels; n++) begin
            if (noise && $urandom_range(0, 9) == 0) send_item(PIX_W'($urandom), 1'b1);
            send_item(make_pixel(style), 1'b0);
        end
        for (int n = 0; n < drains; n++) send_item(PIX_W'($urandom), 1'($urandom));
    endtask

    // One 3x3 frame at maximum gain: the red centre overflows to max_value, the green
    // centre goes negative and clamps to zero. A flush mid-frame must do nothing.
    task automatic test_clamps();
        logic [PIX_W-1:0] px;
        write_reg(CFG_GAIN, 16'h0FFF);
        write_reg(CFG_MAX_VALUE, 16'h00A5);
        write_reg(CFG_COLUMN_LENGTH, 16'd3);
        write_reg(CFG_LINE_COUNT, 16'd3);
        for (int n = 0; n < 9; n++) begin
            if (n == 4) px = {8'h80, 8'h00, 8'hFF};
            else        px = {8'($urandom), 8'hFF, 8'h00};
            send_item(px, 1'b0);
            if (n == 4) send_item(PIX_W'($urandom), 1'b1);
        end
        for (int n = 0; n < 4; n++) send_item(PIX_W'($urandom), 1'(n[0]));
        quiesce();
    endtask

    // Line length and line count below three behave as three.
    task automatic test_length_floor();
        write_reg(CFG_COLUMN_LENGTH, 16'd2);
        write_reg(CFG_LINE_COUNT, 16'd1);
        write_reg(CFG_GAIN, 16'h0100);
        write_reg(CFG_MAX_VALUE, 16'h00FF);
        send_frame(line_len() * frame_rows(), line_len() + 1, PIX_NOISE, 1'b0);
        quiesce();
        write_reg(CFG_COLUMN_LENGTH, 16'd0);
        write_reg(CFG_LINE_COUNT, 16'd0);
        write_reg(CFG_MAX_VALUE, 16'h0000);
        send_frame(line_len() * frame_rows(), line_len() + 1, PIX_EXTREME, 1'b0);
        quiesce();
    endtask

    // A geometry write while a frame is half in restarts the frame from its first pixel.
    task automatic test_restart_mid_frame();
        write_reg(CFG_COLUMN_LENGTH, 16'hA005);
        write_reg(CFG_LINE_COUNT, 16'd4);
        write_reg(CFG_GAIN, 16'h0180);
        send_frame(12, 0, PIX_NOISE, 1'b1);
        quiesce();
        write_reg(CFG_LINE_COUNT, 16'd3);
        send_frame(7, 0, PIX_NOISE, 1'b1);
        quiesce();
        write_reg(CFG_COLUMN_LENGTH, 16'd4);
        send_frame(line_len() * frame_rows(), line_len() + 1, PIX_NOISE, 1'b1);
        quiesce();
    endtask

    // The largest line count: the frame never completes, a rewrite ends it.
    task automatic test_tall_frame();
        write_reg(CFG_COLUMN_LENGTH, 16'd3);
        write_reg(CFG_LINE_COUNT, 16'hFFFF);
        send_frame(40, 0, PIX_EXTREME, 1'b1);
        quiesce();
    endtask

    // Full-width lines. Only the start of such a frame is sent, and nothing may come
    // out before the second line begins.
    task automatic test_widest_lines();
        write_reg(CFG_COLUMN_LENGTH, 16'hF800);
        write_reg(CFG_LINE_COUNT, 16'd0);
        write_reg(CFG_GAIN, 16'h0040);
        send_frame(WIDE_ITEMS, 0, PIX_NOISE, 1'b0);
        quiesce();
        // A length above the store depth is used as the store depth.
        write_reg(CFG_COLUMN_LENGTH, 16'h0FFF);
        write_reg(CFG_LINE_COUNT, 16'd3);
        send_frame(WIDE_ITEMS, 0, PIX_FLAT, 1'b0);
        quiesce();
    endtask

    // Mostly complete frames of random small geometry, some back to back without a
    // register write, some cut short and restarted.
    task automatic test_random_frames(input int budget);
        int          sent;
        int          pixels;
        int          pick;
        int unsigned len_req, rows_req;
        logic [GAIN_W-1:0] g;
        logic [CH_W-1:0]   m;
        bit          reconfig;
        bit          cut;
        sent     = 0;
        reconfig = 1'b1;
        while (sent < budget) begin
            if (reconfig) begin
                quiesce();
                pick = $urandom_range(0, 3);
                g = (pick == 0) ? '0 : (pick == 1) ? '1 : (pick == 2) ? 12'h100
                                                                        : GAIN_W'($urandom);
                pick = $urandom_range(0, 3);
                m = (pick == 0) ? '0 : (pick == 1) ? '1 : CH_W'($urandom);
                pick = $urandom_range(0, 9);
                len_req = (pick < 8) ? $urandom_range(3, 12) :
                          (pick == 8) ? $urandom_range(0, 2) : $urandom_range(13, 40);
                rows_req = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2)
                                                       : $urandom_range(3, 6);
                write_reg(CFG_GAIN, {4'($urandom), g});
                write_reg(CFG_MAX_VALUE, {8'($urandom), m});
                write_reg(CFG_COLUMN_LENGTH, {4'($urandom), 12'(len_req)});
                write_reg(CFG_LINE_COUNT, 16'(rows_req));
            end
            src_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
            sink_idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
            pixels = line_len() * frame_rows();
            cut = ($urandom_range(0, 9) == 0);
            if (cut) pixels = $urandom_range(1, pixels - 1);
            send_frame(pixels, cut ? 0 : line_len() + 1, $urandom_range(PIX_NOISE, PIX_FLAT),
                       1'b1);
            sent += pixels + (cut ? 0 : line_len() + 1);
            reconfig = cut || ($urandom_range(0, 2) != 0);
        end
    endtask

    initial begin : run
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_clamps();
        test_length_floor();
        test_restart_mid_frame();
        test_tall_frame();
        test_widest_lines();
        test_random_frames(RANDOM_ITEMS);
        quiesce();

        if (fail_count == 0) begin
            $display("** sharpen_3x3_rgb_unit: PASSED **");
        end else begin
            $display("** sharpen_3x3_rgb_unit: FAILED **");
        end
        $finish;
    end

endmodule
